### rtl/tracking_velocity_controller_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tracking velocity controller
// Shared property forms, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef TRACKING_VELOCITY_CONTROLLER_ASSERT_SVH
`define TRACKING_VELOCITY_CONTROLLER_ASSERT_SVH

// The property must hold in the same cycle as the condition.
`define TVC_ASSERT_NOW(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// The property must hold in the cycle after the condition.
`define TVC_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

### rtl/tvc_pkg.sv
// ----------------------------------------------------------------------------
// Tracking velocity controller package
// Shared types, codes and fixed tuning constants.
// ----------------------------------------------------------------------------
package tvc_pkg;

	// Item kinds.
	localparam logic [1:0] ACT_POSE    = 2'd0;
	localparam logic [1:0] ACT_MISSION = 2'd1;
	localparam logic [1:0] ACT_TICK    = 2'd2;

	// Tracker status codes.
	localparam logic [1:0] ST_WAIT     = 2'd0;
	localparam logic [1:0] ST_TRACKING = 2'd1;
	localparam logic [1:0] ST_TOO_MANY = 2'd2;

	// Flight modes.
	localparam logic [1:0] MODE_TAKEOFF = 2'd0;
	localparam logic [1:0] MODE_TRACK   = 2'd1;
	localparam logic [1:0] MODE_HOLD    = 2'd2;

	// Register indexes.
	localparam logic [2:0] REG_GAIN_XY      = 3'd0;
	localparam logic [2:0] REG_GAIN_Z       = 3'd1;
	localparam logic [2:0] REG_GAIN_YAW     = 3'd2;
	localparam logic [2:0] REG_LIMIT_XY     = 3'd3;
	localparam logic [2:0] REG_LIMIT_Z      = 3'd4;
	localparam logic [2:0] REG_LIMIT_YAW    = 3'd5;
	localparam logic [2:0] REG_DESIRED      = 3'd6;
	localparam logic [2:0] REG_HOVER_HEIGHT = 3'd7;

	// Fixed-point constants (Q16.16 altitudes, Q3.13 angles, Q0.16 fractions).
	localparam logic signed [31:0] ALT_MISSION_MIN = 32'sd45875;
	localparam logic signed [31:0] ALT_YAW_MIN     = 32'sd19661;
	localparam logic signed [16:0] NEAR_LIMIT      = 17'sd3277;
	localparam logic [15:0]        TENTH_Q16       = 16'd6554;
	localparam logic [15:0]        TWENTIETH_Q16   = 16'd3277;
	localparam logic signed [16:0] PI_Q13          = 17'sd25736;
	localparam logic signed [16:0] TWO_PI_Q13      = 17'sd51472;

	typedef struct packed {
		logic [15:0]        gain_xy;
		logic [15:0]        gain_z;
		logic [15:0]        gain_yaw;
		logic [30:0]        limit_xy;
		logic [30:0]        limit_z;
		logic [14:0]        limit_yaw_rate;
		logic [15:0]        desired_ratio;
		logic signed [31:0] hover_height;
	} cfg_t;

	// Operations issued to the shared multiplier.
	typedef enum logic [2:0] {
		OP_NONE = 3'd0,
		OP_TX   = 3'd1,
		OP_TY   = 3'd2,
		OP_TR   = 3'd3,
		OP_VX   = 3'd4,
		OP_VY   = 3'd5,
		OP_VZ   = 3'd6,
		OP_VR   = 3'd7
	} op_t;

	typedef struct packed {
		logic pose_we;
		logic mission_we;
		logic load_err;
		op_t  op;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic track_mode;
	} stat_t;

endpackage

### rtl/tvc_regs.sv
// ----------------------------------------------------------------------------
// Tracking velocity controller registers
// APB-style configuration registers with read-back.
// ----------------------------------------------------------------------------
module tvc_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [4:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	output tvc_pkg::cfg_t cfg
);
	import tvc_pkg::*;

	logic       wr_en;
	logic [2:0] idx;
	cfg_t       cfg_q;

	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[4:2];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_xy        <= 16'd256;
			cfg_q.gain_z         <= 16'd205;
			cfg_q.gain_yaw       <= 16'd768;
			cfg_q.limit_xy       <= 31'd26214;
			cfg_q.limit_z        <= 31'd13107;
			cfg_q.limit_yaw_rate <= 15'd1229;
			cfg_q.desired_ratio  <= 16'd6554;
			cfg_q.hover_height   <= 32'sd65536;
		end else if (wr_en) begin
			case (idx)
				REG_GAIN_XY:      cfg_q.gain_xy        <= pwdata[15:0];
				REG_GAIN_Z:       cfg_q.gain_z         <= pwdata[15:0];
				REG_GAIN_YAW:     cfg_q.gain_yaw       <= pwdata[15:0];
				REG_LIMIT_XY:     cfg_q.limit_xy       <= pwdata[30:0];
				REG_LIMIT_Z:      cfg_q.limit_z        <= pwdata[30:0];
				REG_LIMIT_YAW:    cfg_q.limit_yaw_rate <= pwdata[14:0];
				REG_DESIRED:      cfg_q.desired_ratio  <= pwdata[15:0];
				REG_HOVER_HEIGHT: cfg_q.hover_height   <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_GAIN_XY:      prdata = {16'd0, cfg_q.gain_xy};
			REG_GAIN_Z:       prdata = {16'd0, cfg_q.gain_z};
			REG_GAIN_YAW:     prdata = {16'd0, cfg_q.gain_yaw};
			REG_LIMIT_XY:     prdata = {1'b0, cfg_q.limit_xy};
			REG_LIMIT_Z:      prdata = {1'b0, cfg_q.limit_z};
			REG_LIMIT_YAW:    prdata = {17'd0, cfg_q.limit_yaw_rate};
			REG_DESIRED:      prdata = {16'd0, cfg_q.desired_ratio};
			REG_HOVER_HEIGHT: prdata = cfg_q.hover_height;
			default:          prdata = 32'd0;
		endcase
	end

endmodule

### rtl/tvc_datapath.sv
// ----------------------------------------------------------------------------
// Tracking velocity controller datapath
// Pose and mission state, error registers, one shared multiplier with a
// rounding and clamping writeback stage, and the result register.
// ----------------------------------------------------------------------------
module tvc_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  tvc_pkg::cfg_t       cfg,
	input  tvc_pkg::cmd_t       cmd,
	output tvc_pkg::stat_t      stat,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic signed [31:0]  pos_z,
	input  logic signed [15:0]  heading,
	input  logic [1:0]          track_status,
	input  logic [15:0]         size_ratio,
	input  logic signed [15:0]  side_offset,
	output logic signed [31:0]  cmd_vx,
	output logic signed [31:0]  cmd_vy,
	output logic signed [31:0]  cmd_vz,
	output logic signed [15:0]  cmd_yaw_rate,
	output logic [1:0]          flight_mode
);
	import tvc_pkg::*;

	// Pose and mission state.
	logic signed [31:0] cur_x_q, cur_y_q, cur_z_q;
	logic signed [15:0] cur_h_q;
	logic signed [31:0] hold_x_q, hold_y_q, hold_z_q;
	logic signed [15:0] hold_h_q;
	logic [1:0]         mode_q;
	logic [15:0]        trk_ratio_q;
	logic signed [15:0] trk_offset_q;

	// Errors of the current tick.
	logic signed [32:0] ex_q, ey_q, ez_q;
	logic signed [15:0] eyaw_q;

	// Multiplier stage.
	logic [48:0] prod_s1;
	logic        neg_s1;
	op_t         op_s1;

	// Results and output register.
	logic signed [31:0] res_vx_q, res_vy_q, res_vz_q;
	logic signed [15:0] res_vr_q;
	logic signed [31:0] out_vx_q, out_vy_q, out_vz_q;
	logic signed [15:0] out_vr_q;
	logic [1:0]         out_mode_q;

	logic               alt_ok;
	logic               low_alt;
	logic signed [16:0] ratio_diff;
	logic signed [16:0] off17;
	logic               near;

	logic signed [32:0] ld_ex, ld_ey, ld_ez;
	logic signed [16:0] yaw_raw, yaw_w1, yaw_w2;

	logic signed [16:0] trk_diff;
	logic signed [32:0] op_a;
	logic [15:0]        op_b;
	logic [32:0]        op_mag;

	logic [4:0]  shamt;
	logic [49:0] rnd_sum;
	logic [49:0] rnd_shift;
	logic [40:0] mag_r;
	logic [40:0] lim;
	logic [40:0] mag_sel;
	logic [41:0] sval;

	logic        vx_in_lim;
	logic        yaw_in_pi;

	assign stat.track_mode = (mode_q == MODE_TRACK);
	assign alt_ok  = (cur_z_q > ALT_MISSION_MIN);
	assign low_alt = (cur_z_q < ALT_YAW_MIN);

	assign ratio_diff = $signed({1'b0, size_ratio}) - $signed({1'b0, cfg.desired_ratio});
	assign off17      = {side_offset[15], side_offset};
	assign near       = (ratio_diff > -NEAR_LIMIT) && (ratio_diff < NEAR_LIMIT) &&
	                    (off17 > -NEAR_LIMIT) && (off17 < NEAR_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			cur_z_q      <= '0;
			cur_h_q      <= '0;
			hold_x_q     <= '0;
			hold_y_q     <= '0;
			hold_z_q     <= '0;
			hold_h_q     <= '0;
			mode_q       <= MODE_TAKEOFF;
			trk_ratio_q  <= '0;
			trk_offset_q <= '0;
		end else if (cmd.pose_we) begin
			cur_x_q <= pos_x;
			cur_y_q <= pos_y;
			cur_z_q <= pos_z;
			cur_h_q <= heading;
		end else if (cmd.mission_we && alt_ok) begin
			case (track_status)
				ST_TRACKING: begin
					if (near) begin
						if (mode_q != MODE_HOLD) begin
							hold_x_q <= cur_x_q;
							hold_y_q <= cur_y_q;
							hold_z_q <= cur_z_q;
							hold_h_q <= cur_h_q;
						end
						mode_q <= MODE_HOLD;
					end else begin
						mode_q       <= MODE_TRACK;
						trk_ratio_q  <= size_ratio;
						trk_offset_q <= side_offset;
					end
				end
				ST_WAIT, ST_TOO_MANY: begin
					mode_q   <= MODE_HOLD;
					hold_x_q <= cur_x_q;
					hold_y_q <= cur_y_q;
					hold_z_q <= cfg.hover_height;
					hold_h_q <= cur_h_q;
				end
				default: ;
			endcase
		end
	end

	// Errors for takeoff and hold; in track mode x, y and yaw are replaced
	// later by the scaled tracker terms.
	always_comb begin
		ld_ez = {cfg.hover_height[31], cfg.hover_height} - {cur_z_q[31], cur_z_q};
		case (mode_q)
			MODE_TAKEOFF: begin
				ld_ex   = 33'sd0 - {cur_x_q[31], cur_x_q};
				ld_ey   = 33'sd0 - {cur_y_q[31], cur_y_q};
				yaw_raw = 17'sd0 - {cur_h_q[15], cur_h_q};
			end
			MODE_TRACK: begin
				ld_ex   = '0;
				ld_ey   = '0;
				yaw_raw = '0;
			end
			default: begin
				ld_ex   = {hold_x_q[31], hold_x_q} - {cur_x_q[31], cur_x_q};
				ld_ey   = {hold_y_q[31], hold_y_q} - {cur_y_q[31], cur_y_q};
				ld_ez   = {hold_z_q[31], hold_z_q} - {cur_z_q[31], cur_z_q};
				yaw_raw = {hold_h_q[15], hold_h_q} - {cur_h_q[15], cur_h_q};
			end
		endcase
	end

	// Two wrap steps bring any difference of two headings into +-pi.
	always_comb begin
		if (yaw_raw > PI_Q13) begin
			yaw_w1 = yaw_raw - TWO_PI_Q13;
		end else if (yaw_raw < -PI_Q13) begin
			yaw_w1 = yaw_raw + TWO_PI_Q13;
		end else begin
			yaw_w1 = yaw_raw;
		end
		if (yaw_w1 > PI_Q13) begin
			yaw_w2 = yaw_w1 - TWO_PI_Q13;
		end else if (yaw_w1 < -PI_Q13) begin
			yaw_w2 = yaw_w1 + TWO_PI_Q13;
		end else begin
			yaw_w2 = yaw_w1;
		end
	end

	// Operand selection for the shared multiplier.
	assign trk_diff = $signed({1'b0, cfg.desired_ratio}) - $signed({1'b0, trk_ratio_q});

	always_comb begin
		case (cmd.op)
			OP_TX: begin
				op_a = {{16{trk_diff[16]}}, trk_diff};
				op_b = TENTH_Q16;
			end
			OP_TY: begin
				op_a = {{17{trk_offset_q[15]}}, trk_offset_q};
				op_b = TENTH_Q16;
			end
			OP_TR: begin
				op_a = {{17{trk_offset_q[15]}}, trk_offset_q};
				op_b = TWENTIETH_Q16;
			end
			OP_VX: begin
				op_a = ex_q;
				op_b = cfg.gain_xy;
			end
			OP_VY: begin
				op_a = ey_q;
				op_b = cfg.gain_xy;
			end
			OP_VZ: begin
				op_a = ez_q;
				op_b = cfg.gain_z;
			end
			OP_VR: begin
				op_a = {{17{eyaw_q[15]}}, eyaw_q};
				op_b = cfg.gain_yaw;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign op_mag = op_a[32] ? (33'd0 - op_a) : op_a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= OP_NONE;
		end else begin
			op_s1 <= cmd.op;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= op_mag * op_b;
		neg_s1  <= op_a[32];
	end

	// Round to nearest with ties away from zero on the magnitude, then clamp.
	always_comb begin
		case (op_s1)
			OP_TX:   shamt = 5'd16;
			OP_TY:   shamt = 5'd15;
			OP_TR:   shamt = 5'd18;
			default: shamt = 5'd8;
		endcase
		case (op_s1)
			OP_VX, OP_VY: lim = {10'd0, cfg.limit_xy};
			OP_VZ:        lim = {10'd0, cfg.limit_z};
			OP_VR:        lim = {26'd0, cfg.limit_yaw_rate};
			default:      lim = '1;
		endcase
	end

	assign rnd_sum   = {1'b0, prod_s1} + (50'd1 << (shamt - 5'd1));
	assign rnd_shift = rnd_sum >> shamt;
	assign mag_r     = rnd_shift[40:0];
	assign mag_sel   = (mag_r > lim) ? lim : mag_r;
	assign sval      = neg_s1 ? (42'd0 - {1'b0, mag_sel}) : {1'b0, mag_sel};

	always_ff @(posedge clk) begin
		if (cmd.load_err) begin
			ex_q   <= ld_ex;
			ey_q   <= ld_ey;
			ez_q   <= ld_ez;
			eyaw_q <= yaw_w2[15:0];
		end else begin
			case (op_s1)
				OP_TX: ex_q     <= sval[32:0];
				OP_TY: ey_q     <= sval[32:0];
				OP_TR: eyaw_q   <= sval[15:0];
				OP_VX: res_vx_q <= sval[31:0];
				OP_VY: res_vy_q <= sval[31:0];
				OP_VZ: res_vz_q <= sval[31:0];
				OP_VR: res_vr_q <= low_alt ? 16'sd0 : sval[15:0];
				default: ;
			endcase
		end
		if (cmd.load_out) begin
			out_vx_q   <= res_vx_q;
			out_vy_q   <= res_vy_q;
			out_vz_q   <= res_vz_q;
			out_vr_q   <= res_vr_q;
			out_mode_q <= mode_q;
		end
	end

	assign cmd_vx       = out_vx_q;
	assign cmd_vy       = out_vy_q;
	assign cmd_vz       = out_vz_q;
	assign cmd_yaw_rate = out_vr_q;
	assign flight_mode  = out_mode_q;

	assign vx_in_lim = (res_vx_q <= $signed({1'b0, cfg.limit_xy})) &&
	                   (res_vx_q >= -$signed({1'b0, cfg.limit_xy}));
	assign yaw_in_pi = (eyaw_q <= PI_Q13) && (eyaw_q >= -PI_Q13);

`include "tracking_velocity_controller_assert.svh"

	`TVC_ASSERT_NEXT(a_yaw_zero_low, op_s1 == OP_VR && low_alt, res_vr_q == 16'sd0, "yaw not zeroed")
	`TVC_ASSERT_NEXT(a_vx_in_limit, op_s1 == OP_VX, vx_in_lim, "x command outside its limit")
	`TVC_ASSERT_NEXT(a_yaw_wrapped, cmd.load_err, yaw_in_pi, "yaw error not wrapped")

endmodule

### rtl/tvc_ctrl.sv
// ----------------------------------------------------------------------------
// Tracking velocity controller sequencer
// Accepts items, steps a tick through the shared multiplier and loads the
// output register.
// ----------------------------------------------------------------------------
module tvc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [1:0]     action,
	output logic           out_valid,
	input  logic           out_ready,
	output tvc_pkg::cmd_t  cmd,
	input  tvc_pkg::stat_t stat
);
	import tvc_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_LOAD = 11'b00000000010,
		S_T_X  = 11'b00000000100,
		S_T_Y  = 11'b00000001000,
		S_T_R  = 11'b00000010000,
		S_G_X  = 11'b00000100000,
		S_G_Y  = 11'b00001000000,
		S_G_Z  = 11'b00010000000,
		S_G_R  = 11'b00100000000,
		S_WB   = 11'b01000000000,
		S_FIN  = 11'b10000000000
	} state_t;

	state_t state_q, state_nx;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_nx       = state_q;
		cmd.pose_we    = 1'b0;
		cmd.mission_we = 1'b0;
		cmd.load_err   = 1'b0;
		cmd.op         = OP_NONE;
		cmd.load_out   = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd.pose_we    = accept && (action == ACT_POSE);
				cmd.mission_we = accept && (action == ACT_MISSION);
				if (accept && (action == ACT_TICK)) begin
					state_nx = S_LOAD;
				end
			end
			S_LOAD: begin
				cmd.load_err = 1'b1;
				state_nx     = stat.track_mode ? S_T_X : S_G_X;
			end
			S_T_X: begin
				cmd.op   = OP_TX;
				state_nx = S_T_Y;
			end
			S_T_Y: begin
				cmd.op   = OP_TY;
				state_nx = S_T_R;
			end
			S_T_R: begin
				cmd.op   = OP_TR;
				state_nx = S_G_X;
			end
			S_G_X: begin
				cmd.op   = OP_VX;
				state_nx = S_G_Y;
			end
			S_G_Y: begin
				cmd.op   = OP_VY;
				state_nx = S_G_Z;
			end
			S_G_Z: begin
				cmd.op   = OP_VZ;
				state_nx = S_G_R;
			end
			S_G_R: begin
				cmd.op   = OP_VR;
				state_nx = S_WB;
			end
			S_WB: begin
				state_nx = S_FIN;
			end
			S_FIN: begin
				// Waits here only while the previous beat is still unclaimed.
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

`include "tracking_velocity_controller_assert.svh"

	`TVC_ASSERT_NEXT(a_tick_starts, accept && action == ACT_TICK, state_q == S_LOAD, "tick did not start the sequence")
	`TVC_ASSERT_NOW(a_out_from_fin, $rose(out_valid_q), $past(state_q) == S_FIN, "result raised outside the final step")
	`TVC_ASSERT_NEXT(a_fin_loads, state_q == S_FIN && out_free, out_valid_q && state_q == S_IDLE, "result not presented after the final step")

endmodule

### rtl/tracking_velocity_controller.sv
// ----------------------------------------------------------------------------
// Tracking velocity controller
// Proportional x, y, z and yaw-rate commands for a drone following a subject,
// with a takeoff, track and hold mode machine and APB-style configuration.
//
//   Channel   Handshake             Beat contents
//   input     in_valid / in_ready   action, pose, status, ratio, offset
//   output    out_valid / out_ready cmd_vx, cmd_vy, cmd_vz, cmd_yaw_rate,
//                                   flight_mode
//   config    psel / penable        paddr, pwdata, prdata
//
// Pose and mission items are stored as they are accepted. A tick item runs
// through load, the multiplier steps, writeback and the final step: one shared
// multiplier runs one product per cycle, three extra in track mode.
// The result sits in an output register, so new items are taken while it waits;
// a tick stalls only in its last step while the previous result is unclaimed.
// Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module tracking_velocity_controller (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [15:0] heading,
	input  logic [1:0]         track_status,
	input  logic [15:0]        size_ratio,
	input  logic signed [15:0] side_offset,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] cmd_vx,
	output logic signed [31:0] cmd_vy,
	output logic signed [31:0] cmd_vz,
	output logic signed [15:0] cmd_yaw_rate,
	output logic [1:0]         flight_mode
);
	import tvc_pkg::*;

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;

	tvc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tvc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	tvc_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.stat         (stat),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.heading      (heading),
		.track_status (track_status),
		.size_ratio   (size_ratio),
		.side_offset  (side_offset),
		.cmd_vx       (cmd_vx),
		.cmd_vy       (cmd_vy),
		.cmd_vz       (cmd_vz),
		.cmd_yaw_rate (cmd_yaw_rate),
		.flight_mode  (flight_mode)
	);

endmodule

### tb/sv/tracking_velocity_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracking velocity controller testbench
// Drives pose, mission and tick beats with random gaps on both channels and
// predicts every command beat from its own copy of the mode machine, the pose
// store and the register file. Registers are rewritten between phases once
// the block has drained, and read back after each write.
// ----------------------------------------------------------------------------
module tracking_velocity_controller_tb;
	import tvc_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam logic [1:0] ST_IGNORED = 2'd3;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] heading;
		logic [1:0]         track_status;
		logic [15:0]        size_ratio;
		logic signed [15:0] side_offset;
	} tvc_item_t;

	typedef struct packed {
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
		logic signed [15:0] yaw_rate;
		logic [1:0]         mode;
	} cmd_beat_t;

	class velocity_scoreboard;
		cfg_t               cfg;
		logic signed [31:0] pos_now [3];
		logic signed [15:0] hdg_now;
		logic signed [31:0] pos_hold [3];
		logic signed [15:0] hdg_hold;
		logic [1:0]         mode;
		logic [15:0]        trk_ratio;
		logic signed [15:0] trk_offset;
		cmd_beat_t          cmd_expected [$];
		int                 errors;

		function new();
			cfg.gain_xy        = 16'd256;
			cfg.gain_z         = 16'd205;
			cfg.gain_yaw       = 16'd768;
			cfg.limit_xy       = 31'd26214;
			cfg.limit_z        = 31'd13107;
			cfg.limit_yaw_rate = 15'd1229;
			cfg.desired_ratio  = 16'd6554;
			cfg.hover_height   = 32'sd65536;
			foreach (pos_now[i]) begin
				pos_now[i]  = '0;
				pos_hold[i] = '0;
			end
			hdg_now    = '0;
			hdg_hold   = '0;
			mode       = MODE_TAKEOFF;
			trk_ratio  = '0;
			trk_offset = '0;
			errors     = 0;
		endfunction

		// round(a * b / 2^sh) with ties away from zero.
		static function longint scale_round(longint a, longint b, int sh);
			longint mag;
			mag = (a < 0) ? -a : a;
			mag = (mag * b + (longint'(1) << (sh - 1))) >> sh;
			return (a < 0) ? -mag : mag;
		endfunction

		static function longint clamp_mag(longint v, longint lim);
			if (v > lim) return lim;
			if (v < -lim) return -lim;
			return v;
		endfunction

		function int pending();
			return cmd_expected.size();
		endfunction

		function void mismatch(string what, longint want, longint got);
			if (errors < 100) $error("%s expected %0d got %0d", what, want, got);
			errors++;
		endfunction

		// Updates the register copy and returns what a read should give back.
		function logic [31:0] write_reg(logic [2:0] idx, logic [31:0] v);
			case (idx)
				REG_GAIN_XY: begin
					cfg.gain_xy = v[15:0];
					return {16'd0, v[15:0]};
				end
				REG_GAIN_Z: begin
					cfg.gain_z = v[15:0];
					return {16'd0, v[15:0]};
				end
				REG_GAIN_YAW: begin
					cfg.gain_yaw = v[15:0];
					return {16'd0, v[15:0]};
				end
				REG_LIMIT_XY: begin
					cfg.limit_xy = v[30:0];
					return {1'b0, v[30:0]};
				end
				REG_LIMIT_Z: begin
					cfg.limit_z = v[30:0];
					return {1'b0, v[30:0]};
				end
				REG_LIMIT_YAW: begin
					cfg.limit_yaw_rate = v[14:0];
					return {17'd0, v[14:0]};
				end
				REG_DESIRED: begin
					cfg.desired_ratio = v[15:0];
					return {16'd0, v[15:0]};
				end
				REG_HOVER_HEIGHT: begin
					cfg.hover_height = v;
					return v;
				end
				default: return '0;
			endcase
		endfunction

		function void accept_item(tvc_item_t it);
			longint    dr, ofs, ex, ey, ez, eyaw, hover;
			cmd_beat_t beat;
			hover = longint'($signed(cfg.hover_height));
			case (it.action)
				ACT_POSE: begin
					pos_now[0] = it.pos_x;
					pos_now[1] = it.pos_y;
					pos_now[2] = it.pos_z;
					hdg_now    = it.heading;
				end
				ACT_MISSION: begin
					// The mode machine only moves once the drone is clear of the ground.
					if (longint'(pos_now[2]) > longint'(ALT_MISSION_MIN)) begin
						dr  = longint'(it.size_ratio) - longint'(cfg.desired_ratio);
						ofs = longint'(it.side_offset);
						if (it.track_status == ST_TRACKING) begin
							if ((dr < 0 ? -dr : dr) < longint'(NEAR_LIMIT) &&
									(ofs < 0 ? -ofs : ofs) < longint'(NEAR_LIMIT)) begin
								if (mode != MODE_HOLD) begin
									pos_hold = pos_now;
									hdg_hold = hdg_now;
								end
								mode = MODE_HOLD;
							end else begin
								mode       = MODE_TRACK;
								trk_ratio  = it.size_ratio;
								trk_offset = it.side_offset;
							end
						end else if (it.track_status == ST_WAIT ||
								it.track_status == ST_TOO_MANY) begin
							mode        = MODE_HOLD;
							pos_hold[0] = pos_now[0];
							pos_hold[1] = pos_now[1];
							pos_hold[2] = cfg.hover_height;
							hdg_hold    = hdg_now;
						end
					end
				end
				ACT_TICK: begin
					case (mode)
						MODE_TAKEOFF: begin
							ex   = -longint'(pos_now[0]);
							ey   = -longint'(pos_now[1]);
							ez   = hover - longint'(pos_now[2]);
							eyaw = -longint'(hdg_now);
						end
						MODE_TRACK: begin
							ex   = scale_round(longint'(cfg.desired_ratio) - longint'(trk_ratio),
									longint'(TENTH_Q16), 16);
							ey   = scale_round(longint'(trk_offset), longint'(TENTH_Q16), 15);
							ez   = hover - longint'(pos_now[2]);
							eyaw = scale_round(longint'(trk_offset), longint'(TWENTIETH_Q16), 18);
						end
						default: begin
							ex   = longint'(pos_hold[0]) - longint'(pos_now[0]);
							ey   = longint'(pos_hold[1]) - longint'(pos_now[1]);
							ez   = longint'(pos_hold[2]) - longint'(pos_now[2]);
							eyaw = longint'(hdg_hold) - longint'(hdg_now);
						end
					endcase
					while ((eyaw < 0 ? -eyaw : eyaw) > longint'(PI_Q13))
						eyaw = (eyaw > 0) ? eyaw - longint'(TWO_PI_Q13)
								: eyaw + longint'(TWO_PI_Q13);
					ex   = clamp_mag(scale_round(ex, longint'(cfg.gain_xy), 8),
							longint'(cfg.limit_xy));
					ey   = clamp_mag(scale_round(ey, longint'(cfg.gain_xy), 8),
							longint'(cfg.limit_xy));
					ez   = clamp_mag(scale_round(ez, longint'(cfg.gain_z), 8),
							longint'(cfg.limit_z));
					eyaw = clamp_mag(scale_round(eyaw, longint'(cfg.gain_yaw), 8),
							longint'(cfg.limit_yaw_rate));
					if (pos_now[2] < ALT_YAW_MIN) eyaw = 0;
					beat.vx       = ex[31:0];
					beat.vy       = ey[31:0];
					beat.vz       = ez[31:0];
					beat.yaw_rate = eyaw[15:0];
					beat.mode     = mode;
					cmd_expected.push_back(beat);
				end
				default: ;
			endcase
		endfunction

		function void check_cmd(cmd_beat_t got);
			cmd_beat_t want;
			if (cmd_expected.size() == 0) begin
				if (errors < 100) $error("command beat with no tick waiting: vx %0d mode %0d",
						got.vx, got.mode);
				errors++;
				return;
			end
			want = cmd_expected.pop_front();
			if (got.vx !== want.vx) mismatch("cmd_vx", want.vx, got.vx);
			if (got.vy !== want.vy) mismatch("cmd_vy", want.vy, got.vy);
			if (got.vz !== want.vz) mismatch("cmd_vz", want.vz, got.vz);
			if (got.yaw_rate !== want.yaw_rate)
				mismatch("cmd_yaw_rate", want.yaw_rate, got.yaw_rate);
			if (got.mode !== want.mode) mismatch("flight_mode", want.mode, got.mode);
		endfunction
	endclass

	logic               clk            = 1'b0;
	logic               arst_n         = 1'b0;
	logic               psel           = 1'b0;
	logic               penable        = 1'b0;
	logic               pwrite         = 1'b0;
	logic [4:0]         paddr          = '0;
	logic [31:0]        pwdata         = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid       = 1'b0;
	logic               in_ready;
	logic [1:0]         action         = ACT_POSE;
	logic signed [31:0] pos_x          = '0;
	logic signed [31:0] pos_y          = '0;
	logic signed [31:0] pos_z          = '0;
	logic signed [15:0] heading        = '0;
	logic [1:0]         track_status   = ST_WAIT;
	logic [15:0]        size_ratio     = '0;
	logic signed [15:0] side_offset    = '0;
	logic               out_valid;
	logic               out_ready      = 1'b0;
	logic signed [31:0] cmd_vx;
	logic signed [31:0] cmd_vy;
	logic signed [31:0] cmd_vz;
	logic signed [15:0] cmd_yaw_rate;
	logic [1:0]         flight_mode;

	velocity_scoreboard sb = new();
	bit                 send_calm = 1'b0;
	bit                 recv_calm = 1'b0;
	int                 recv_hold = 0;

	tracking_velocity_controller dut (.*);

	always #1 clk = ~clk;

	function automatic int gap_len(bit calm);
		int r = $urandom_range(0, 99);
		if (calm || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic tvc_item_t make_item(logic [1:0] act);
		tvc_item_t it;
		it.action       = act;
		it.pos_x        = $urandom;
		it.pos_y        = $urandom;
		it.pos_z        = $urandom;
		it.heading      = 16'($urandom_range(0, 51472) - 25736);
		it.track_status = 2'($urandom_range(0, 3));
		it.size_ratio   = 16'($urandom);
		it.side_offset  = 16'($urandom);
		return it;
	endfunction

	function automatic tvc_item_t pose_item(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z, logic signed [15:0] h);
		tvc_item_t it = make_item(ACT_POSE);
		it.pos_x   = x;
		it.pos_y   = y;
		it.pos_z   = z;
		it.heading = h;
		return it;
	endfunction

	function automatic tvc_item_t mission_item(logic [1:0] st, logic [15:0] ratio,
			logic signed [15:0] ofs);
		tvc_item_t it = make_item(ACT_MISSION);
		it.track_status = st;
		it.size_ratio   = ratio;
		it.side_offset  = ofs;
		return it;
	endfunction

	function automatic logic signed [31:0] rand_coord();
		if ($urandom_range(0, 9) == 0) return $urandom;
		return $urandom_range(0, 524288) - 262144;
	endfunction

	// Altitudes mostly span the ground to 3 m, with the thresholds hit often.
	function automatic logic signed [31:0] rand_alt();
		case ($urandom_range(0, 9))
			0:       return $urandom;
			1:       return 19661 + $urandom_range(0, 4) - 2;
			2:       return 45875 + $urandom_range(0, 4) - 2;
			3:       return 0 - $urandom_range(0, 65536);
			default: return $urandom_range(0, 196608);
		endcase
	endfunction

	function automatic tvc_item_t rand_item();
		int         pick = $urandom_range(0, 99);
		int         s    = $urandom_range(0, 19);
		int         r;
		logic [1:0] st;
		logic [15:0] ofs;
		if (pick < 30)
			return pose_item(rand_coord(), rand_coord(), rand_alt(),
					16'($urandom_range(0, 51472) - 25736));
		if (pick < 62) begin
			st = (s < 12) ? ST_TRACKING : (s < 15) ? ST_WAIT : (s < 18) ? ST_TOO_MANY : ST_IGNORED;
			if ($urandom_range(0, 4) < 2) begin
				r = int'(sb.cfg.desired_ratio) + int'($urandom_range(0, 6600)) - 3300;
				if (r < 0) r = 0;
				if (r > 65535) r = 65535;
			end else begin
				r = $urandom_range(0, 65535);
			end
			ofs = ($urandom_range(0, 4) < 2) ? 16'($urandom_range(0, 6600) - 3300)
					: 16'($urandom);
			return mission_item(st, r[15:0], ofs);
		end
		if (pick < 94) return make_item(ACT_TICK);
		return make_item(ACT_UNUSED);
	endfunction

	task automatic drain_cmds();
		int w = 0;
		do begin
			@(posedge clk);
			w++;
		end while (sb.pending() != 0 && w < 200000);
	endtask

	// Presents one beat, waits for it to be taken, then idles or drains.
	task automatic push_item(input tvc_item_t it, input bit hold_off);
		int n;
		in_valid     <= 1'b1;
		action       <= it.action;
		pos_x        <= it.pos_x;
		pos_y        <= it.pos_y;
		pos_z        <= it.pos_z;
		heading      <= it.heading;
		track_status <= it.track_status;
		size_ratio   <= it.size_ratio;
		side_offset  <= it.side_offset;
		do @(posedge clk); while (!in_ready);
		sb.accept_item(it);
		if (hold_off) begin
			in_valid <= 1'b0;
			drain_cmds();
		end else begin
			n = gap_len(send_calm);
			if (n > 0) begin
				in_valid <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	endtask

	task automatic apb_write(input logic [2:0] idx, input logic [31:0] v);
		logic [31:0] want;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		want = sb.write_reg(idx, v);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) sb.mismatch("prdata", want, prdata);
	endtask

	task automatic program_phase(input int p);
		logic [2:0]  regs [8] = '{REG_GAIN_XY, REG_GAIN_Z, REG_GAIN_YAW, REG_LIMIT_XY,
				REG_LIMIT_Z, REG_LIMIT_YAW, REG_DESIRED, REG_HOVER_HEIGHT};
		int          width [8] = '{16, 16, 16, 31, 31, 15, 16, 32};
		logic [31:0] v [8];
		for (int i = 0; i < 8; i++) begin
			if (p == 1) begin
				// All ones also sets the bits above each register's width.
				v[i] = (regs[i] == REG_HOVER_HEIGHT) ? 32'h7FFF_FFFF : 32'hFFFF_FFFF;
			end else if (p == 2) begin
				v[i] = (regs[i] == REG_HOVER_HEIGHT) ? 32'h8000_0000 : 32'h0;
			end else begin
				case (regs[i])
					REG_GAIN_XY, REG_GAIN_Z, REG_GAIN_YAW:
						v[i] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
								: $urandom_range(0, 1024);
					REG_LIMIT_XY, REG_LIMIT_Z:
						v[i] = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 400000);
					REG_LIMIT_YAW: v[i] = $urandom_range(0, 32767);
					REG_DESIRED:   v[i] = $urandom_range(0, 65535);
					default:
						v[i] = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 196608);
				endcase
				if (width[i] < 32 && $urandom_range(0, 1) == 1) v[i] |= $urandom << width[i];
			end
			apb_write(regs[i], v[i]);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_cmd(cmd_beat_t'({cmd_vx, cmd_vy, cmd_vz, cmd_yaw_rate, flight_mode}));
		if ($urandom_range(0, 299) == 0) recv_calm <= !recv_calm;
		if (recv_hold != 0) begin
			recv_hold <= recv_hold - 1;
			out_ready <= 1'b0;
		end else if (!recv_calm && $urandom_range(0, 2) == 0) begin
			recv_hold <= gap_len(1'b0);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Takeoff from the origin, then at the coordinate extremes.
		push_item(make_item(ACT_TICK), 1'b0);
		push_item(pose_item(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'sd25736), 1'b0);
		push_item(make_item(ACT_TICK), 1'b0);
		push_item(pose_item(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, -16'sd25736), 1'b0);
		push_item(make_item(ACT_TICK), 1'b0);
		// Exactly 0.7 m is still too low for a mission beat to count.
		push_item(pose_item(32'sd1000, -32'sd2000, 32'sd45875, 16'sd1234), 1'b0);
		push_item(mission_item(ST_TRACKING, 16'hFFFF, 16'sh8000), 1'b0);
		push_item(make_item(ACT_TICK), 1'b0);
		push_item(pose_item(32'sd1000, -32'sd2000, 32'sd45876, -16'sd25736), 1'b0);
		push_item(mission_item(ST_IGNORED, 16'd0, 16'sd0), 1'b0);
		push_item(make_item(ACT_TICK), 1'b0);
		// Far from the subject: track mode with the extreme ratio and offsets.
		push_item(mission_item(ST_TRACKING, 16'hFFFF, 16'sh8000), 1'b0);
		push_item(make_item(ACT_TICK), 1'b0);
		push_item(mission_item(ST_TRACKING, 16'h0000, 16'sh7FFF), 1'b0);
		push_item(make_item(ACT_TICK), 1'b0);
		// Near the subject: the hold pose is captured once, not on a second near beat.
		push_item(mission_item(ST_TRACKING, 16'd9830, -16'sd3276), 1'b0);
		push_item(pose_item(32'sd5000, 32'sd6000, 32'sd70000, 16'sd25000), 1'b0);
		push_item(make_item(ACT_TICK), 1'b0);
		push_item(mission_item(ST_TRACKING, 16'd3278, 16'sd3276), 1'b0);
		push_item(pose_item(-32'sd7000, 32'sd0, 32'sd19660, -16'sd25000), 1'b0);
		push_item(make_item(ACT_TICK), 1'b0);
		push_item(pose_item(32'sd0, 32'sd0, 32'sd19661, -16'sd25000), 1'b0);
		push_item(make_item(ACT_TICK), 1'b0);
		// A ratio exactly at the near distance is not near.
		push_item(pose_item(32'sd300, -32'sd300, 32'sd131072, 16'sd100), 1'b0);
		push_item(mission_item(ST_TRACKING, 16'd9831, 16'sd0), 1'b0);
		push_item(make_item(ACT_TICK), 1'b0);
		push_item(mission_item(ST_WAIT, 16'd0, 16'sd0), 1'b0);
		push_item(make_item(ACT_TICK), 1'b0);
		push_item(mission_item(ST_TOO_MANY, 16'd0, 16'sd0), 1'b0);
		push_item(make_item(ACT_UNUSED), 1'b0);
		push_item(make_item(ACT_TICK), 1'b1);

		for (int p = 0; p < 8; p++) begin
			if (p > 0) begin
				in_valid <= 1'b0;
				drain_cmds();
				// Pose and mission beats leave no result, so give them time to land.
				repeat (20) @(posedge clk);
				program_phase(p);
			end
			send_calm = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < 85; k++)
				push_item(rand_item(), $urandom_range(0, 59) == 0);
		end

		in_valid <= 1'b0;
		drain_cmds();
		repeat (30) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			if (sb.pending() != 0) $error("%0d command beats never arrived", sb.pending());
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule
